// ===== rtl/nth_pkg.sv =====
package nth_pkg;

	localparam int COORD_W   = 32;
	localparam int FACE_W    = 16;
	localparam int SKIP_W    = FACE_W + 1;
	localparam int EDGE_W    = COORD_W + 1;
	localparam int SM_W      = EDGE_W + 1;
	localparam int CROSS_W   = 2 * EDGE_W + 1;
	localparam int DOT_W     = EDGE_W + CROSS_W + 4;
	localparam int FRAC_W    = 16;
	localparam int TQ_W      = DOT_W - 2 + FRAC_W;
	localparam int ACC_W     = TQ_W + SM_W;
	localparam int DIST_W    = 48;
	localparam int DET_EPSILON = 1;
	localparam int QDEPTH    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int OP_W      = 5;
	localparam int STEP_W    = 6;
	localparam int DIV_CNT_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP     = 3'd6;

	localparam logic [OP_W-1:0] OP_FIRST   = 5'd0;
	localparam logic [OP_W-1:0] OP_TN_END  = 5'd23;
	localparam logic [OP_W-1:0] OP_PT_X    = 5'd24;
	localparam logic [OP_W-1:0] OP_PT_END  = 5'd26;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] org;
		logic [2:0][COORD_W-1:0] dir;
	} ray_t;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] v0;
		logic [2:0][COORD_W-1:0] v1;
		logic [2:0][COORD_W-1:0] v2;
		logic [FACE_W-1:0]       face;
		logic                    last;
		logic                    skip;
	} item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOAD,
		BK_MAC,
		BK_NORM,
		BK_TEST,
		BK_DIV,
		BK_PICK,
		BK_EMIT
	} back_state_t;

endpackage

// ===== rtl/nth_front.sv =====
module nth_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nth_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nth_pkg::COORD_W-1:0]         cfg_data,
	input  logic                                push,
	output logic                                full,
	input  nth_pkg::item_t                      in_item,
	input  logic                                q_pop,
	output logic                                q_empty,
	output nth_pkg::item_t                      q_item,
	output nth_pkg::ray_t                       ray
);

	nth_pkg::ray_t               ray_q;
	logic [nth_pkg::SKIP_W-1:0]  skip_q;
	nth_pkg::item_t              slot_q [nth_pkg::QDEPTH];
	logic                        wr_ptr_q;
	logic                        rd_ptr_q;
	logic [1:0]                  cnt_q;
	logic                        push_ok;
	logic                        pop_ok;
	nth_pkg::item_t              tagged_item;

	assign cfg_ready = 1'b1;
	assign ray       = ray_q;
	assign full      = (cnt_q == 2'(nth_pkg::QDEPTH));
	assign q_empty   = (cnt_q == 2'd0);
	assign q_item    = slot_q[rd_ptr_q];
	assign push_ok   = push && !full;
	assign pop_ok    = q_pop && !q_empty;

	always_comb begin
		tagged_item = in_item;
		tagged_item.skip = !skip_q[nth_pkg::SKIP_W-1]
			&& (skip_q[nth_pkg::FACE_W-1:0] == in_item.face);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_q.org <= '0;
			ray_q.dir <= {32'sd65536, 32'sd0, 32'sd0};
			skip_q    <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				nth_pkg::REG_ORIGIN_X: ray_q.org[0] <= cfg_data;
				nth_pkg::REG_ORIGIN_Y: ray_q.org[1] <= cfg_data;
				nth_pkg::REG_ORIGIN_Z: ray_q.org[2] <= cfg_data;
				nth_pkg::REG_DIR_X:    ray_q.dir[0] <= cfg_data;
				nth_pkg::REG_DIR_Y:    ray_q.dir[1] <= cfg_data;
				nth_pkg::REG_DIR_Z:    ray_q.dir[2] <= cfg_data;
				nth_pkg::REG_SKIP:     skip_q <= cfg_data[nth_pkg::SKIP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_ok) wr_ptr_q <= !wr_ptr_q;
			if (pop_ok) rd_ptr_q <= !rd_ptr_q;
			if (push_ok && !pop_ok) cnt_q <= cnt_q + 2'd1;
			else if (pop_ok && !push_ok) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) slot_q[wr_ptr_q] <= tagged_item;
	end

endmodule

// ===== rtl/nth_back.sv =====
module nth_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nth_pkg::ray_t                     ray,
	input  logic                              q_empty,
	input  nth_pkg::item_t                    q_item,
	output logic                              q_pop,
	input  logic                              pop,
	output logic                              empty,
	output logic                              hit_found,
	output logic [nth_pkg::FACE_W-1:0]        nearest_face,
	output logic signed [nth_pkg::COORD_W-1:0] point_x,
	output logic signed [nth_pkg::COORD_W-1:0] point_y,
	output logic signed [nth_pkg::COORD_W-1:0] point_z
);

	localparam int ACC_W   = nth_pkg::ACC_W;
	localparam int SM_W    = nth_pkg::SM_W;
	localparam int DOT_W   = nth_pkg::DOT_W;
	localparam int TQ_W    = nth_pkg::TQ_W;
	localparam int CROSS_W = nth_pkg::CROSS_W;
	localparam int EDGE_W  = nth_pkg::EDGE_W;
	localparam int COORD_W = nth_pkg::COORD_W;
	localparam int DIST_W  = nth_pkg::DIST_W;
	localparam int FRAC_W  = nth_pkg::FRAC_W;
	localparam int SH_W    = ACC_W - FRAC_W;

	nth_pkg::back_state_t state_q, state_d;

	logic signed [EDGE_W-1:0]  e0_q [3];
	logic signed [EDGE_W-1:0]  e1_q [3];
	logic signed [EDGE_W-1:0]  s_q  [3];
	logic signed [CROSS_W-1:0] h_q  [3];
	logic signed [CROSS_W-1:0] qv_q [3];
	logic signed [DOT_W-1:0]   det_q, un_q, vn_q, tn_q;
	logic [nth_pkg::FACE_W-1:0] face_q;
	logic                      last_q;

	logic [nth_pkg::OP_W-1:0]   op_q;
	logic [nth_pkg::STEP_W-1:0] step_q;
	logic signed [ACC_W-1:0]    acc_q, w_q;
	logic signed [SM_W-1:0]     sreg_q;
	logic                       sub_q;

	logic [TQ_W-1:0]            num_q;
	logic [DOT_W:0]             rem_q;
	logic [nth_pkg::DIV_CNT_W-1:0] div_cnt_q;

	logic                       have_hit_q;
	logic [DIST_W-1:0]          best_dist_q;
	logic [nth_pkg::FACE_W-1:0] best_face_q;
	logic [COORD_W-1:0]         best_pt_q [3];
	logic                       out_valid_q;

	logic [nth_pkg::OP_W-1:0]   ld_op;
	logic [1:0]                 ld_axis, pt_axis;
	logic signed [SM_W-1:0]     ld_sm;
	logic signed [ACC_W-1:0]    ld_wd, ld_acc;
	logic                       ld_sub, ld_clr;
	logic                       mac_neg, op_done;
	logic signed [ACC_W-1:0]    term, acc_sum;
	logic signed [SH_W-1:0]     sh;
	logic [COORD_W-1:0]         sat_pt;
	logic signed [DOT_W:0]      uv;
	logic                       hit;
	logic [DOT_W:0]             rem_sh, diff;
	logic [DIST_W-1:0]          tq_dist;
	logic                       update, emit_ok, div_done;

	assign empty        = !out_valid_q;
	assign op_done      = (state_q == nth_pkg::BK_MAC) && (step_q == nth_pkg::STEP_W'(SM_W - 1));
	assign div_done     = (div_cnt_q == nth_pkg::DIV_CNT_W'(TQ_W - 1));
	assign ld_axis      = 2'(ld_op - nth_pkg::OP_PT_X);
	assign pt_axis      = 2'(op_q - nth_pkg::OP_PT_X);

	always_comb begin
		unique case (state_q)
			nth_pkg::BK_LOAD: ld_op = nth_pkg::OP_FIRST;
			nth_pkg::BK_PICK: ld_op = nth_pkg::OP_PT_X;
			default:          ld_op = op_q + nth_pkg::OP_W'(1);
		endcase
	end

	always_comb begin
		ld_sm  = '0;
		ld_wd  = '0;
		ld_sub = 1'b0;
		ld_clr = 1'b0;
		ld_acc = '0;
		unique case (ld_op)
			5'd0:  begin ld_sm = SM_W'($signed(ray.dir[1])); ld_wd = ACC_W'(e1_q[2]); ld_clr = 1'b1; end
			5'd1:  begin ld_sm = SM_W'($signed(ray.dir[2])); ld_wd = ACC_W'(e1_q[1]); ld_sub = 1'b1; end
			5'd2:  begin ld_sm = SM_W'($signed(ray.dir[2])); ld_wd = ACC_W'(e1_q[0]); ld_clr = 1'b1; end
			5'd3:  begin ld_sm = SM_W'($signed(ray.dir[0])); ld_wd = ACC_W'(e1_q[2]); ld_sub = 1'b1; end
			5'd4:  begin ld_sm = SM_W'($signed(ray.dir[0])); ld_wd = ACC_W'(e1_q[1]); ld_clr = 1'b1; end
			5'd5:  begin ld_sm = SM_W'($signed(ray.dir[1])); ld_wd = ACC_W'(e1_q[0]); ld_sub = 1'b1; end
			5'd6:  begin ld_sm = SM_W'(s_q[1]); ld_wd = ACC_W'(e0_q[2]); ld_clr = 1'b1; end
			5'd7:  begin ld_sm = SM_W'(s_q[2]); ld_wd = ACC_W'(e0_q[1]); ld_sub = 1'b1; end
			5'd8:  begin ld_sm = SM_W'(s_q[2]); ld_wd = ACC_W'(e0_q[0]); ld_clr = 1'b1; end
			5'd9:  begin ld_sm = SM_W'(s_q[0]); ld_wd = ACC_W'(e0_q[2]); ld_sub = 1'b1; end
			5'd10: begin ld_sm = SM_W'(s_q[0]); ld_wd = ACC_W'(e0_q[1]); ld_clr = 1'b1; end
			5'd11: begin ld_sm = SM_W'(s_q[1]); ld_wd = ACC_W'(e0_q[0]); ld_sub = 1'b1; end
			5'd12: begin ld_sm = SM_W'(e0_q[0]); ld_wd = ACC_W'(h_q[0]); ld_clr = 1'b1; end
			5'd13: begin ld_sm = SM_W'(e0_q[1]); ld_wd = ACC_W'(h_q[1]); end
			5'd14: begin ld_sm = SM_W'(e0_q[2]); ld_wd = ACC_W'(h_q[2]); end
			5'd15: begin ld_sm = SM_W'(s_q[0]); ld_wd = ACC_W'(h_q[0]); ld_clr = 1'b1; end
			5'd16: begin ld_sm = SM_W'(s_q[1]); ld_wd = ACC_W'(h_q[1]); end
			5'd17: begin ld_sm = SM_W'(s_q[2]); ld_wd = ACC_W'(h_q[2]); end
			5'd18: begin ld_sm = SM_W'($signed(ray.dir[0])); ld_wd = ACC_W'(qv_q[0]); ld_clr = 1'b1; end
			5'd19: begin ld_sm = SM_W'($signed(ray.dir[1])); ld_wd = ACC_W'(qv_q[1]); end
			5'd20: begin ld_sm = SM_W'($signed(ray.dir[2])); ld_wd = ACC_W'(qv_q[2]); end
			5'd21: begin ld_sm = SM_W'(e1_q[0]); ld_wd = ACC_W'(qv_q[0]); ld_clr = 1'b1; end
			5'd22: begin ld_sm = SM_W'(e1_q[1]); ld_wd = ACC_W'(qv_q[1]); end
			5'd23: begin ld_sm = SM_W'(e1_q[2]); ld_wd = ACC_W'(qv_q[2]); end
			5'd24, 5'd25, 5'd26: begin
				ld_sm  = SM_W'($signed(ray.dir[ld_axis]));
				ld_wd  = ACC_W'(num_q);
				ld_clr = 1'b1;
				ld_acc = ACC_W'($signed(ray.org[ld_axis])) <<< FRAC_W;
			end
			default: ;
		endcase
	end

	always_comb begin
		mac_neg = sub_q ^ (step_q == nth_pkg::STEP_W'(SM_W - 1));
		if (!sreg_q[0]) term = '0;
		else if (mac_neg) term = -w_q;
		else term = w_q;
		acc_sum = acc_q + term;
		sh = acc_sum[ACC_W-1:FRAC_W];
		if (sh[SH_W-1:COORD_W-1] == '0 || sh[SH_W-1:COORD_W-1] == '1) begin
			sat_pt = sh[COORD_W-1:0];
		end else begin
			sat_pt = sh[SH_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

	always_comb begin
		uv  = (DOT_W+1)'(un_q) + (DOT_W+1)'(vn_q);
		hit = (det_q != '0) && (det_q >= DOT_W'(nth_pkg::DET_EPSILON))
			&& !un_q[DOT_W-1] && (un_q <= det_q)
			&& !vn_q[DOT_W-1] && (uv <= (DOT_W+1)'(det_q))
			&& !tn_q[DOT_W-1] && (tn_q != '0);
		rem_sh  = {rem_q[DOT_W-1:0], num_q[TQ_W-1]};
		diff    = rem_sh - {1'b0, det_q};
		tq_dist = (num_q[TQ_W-1:DIST_W] != '0) ? '1 : num_q[DIST_W-1:0];
		update  = !have_hit_q || (tq_dist < best_dist_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nth_pkg::BK_IDLE: begin
				if (!q_empty) state_d = q_item.skip
					? (q_item.last ? nth_pkg::BK_EMIT : nth_pkg::BK_IDLE) : nth_pkg::BK_LOAD;
			end
			nth_pkg::BK_LOAD: state_d = nth_pkg::BK_MAC;
			nth_pkg::BK_MAC: begin
				if (op_done && op_q == nth_pkg::OP_TN_END) state_d = nth_pkg::BK_NORM;
				else if (op_done && op_q == nth_pkg::OP_PT_END)
					state_d = last_q ? nth_pkg::BK_EMIT : nth_pkg::BK_IDLE;
			end
			nth_pkg::BK_NORM: state_d = nth_pkg::BK_TEST;
			nth_pkg::BK_TEST: begin
				if (hit) state_d = nth_pkg::BK_DIV;
				else state_d = last_q ? nth_pkg::BK_EMIT : nth_pkg::BK_IDLE;
			end
			nth_pkg::BK_DIV: if (div_done) state_d = nth_pkg::BK_PICK;
			nth_pkg::BK_PICK: begin
				if (update) state_d = nth_pkg::BK_MAC;
				else state_d = last_q ? nth_pkg::BK_EMIT : nth_pkg::BK_IDLE;
			end
			nth_pkg::BK_EMIT: if (emit_ok) state_d = nth_pkg::BK_IDLE;
			default: state_d = nth_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop   = (state_q == nth_pkg::BK_IDLE) && !q_empty;
		emit_ok = (state_q == nth_pkg::BK_EMIT) && (!out_valid_q || pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nth_pkg::BK_IDLE;
			have_hit_q  <= 1'b0;
			best_dist_q <= '1;
			best_face_q <= '0;
			best_pt_q   <= '{default: '0};
			out_valid_q <= 1'b0;
			hit_found   <= 1'b0;
			nearest_face <= '0;
			point_x     <= '0;
			point_y     <= '0;
			point_z     <= '0;
		end else begin
			state_q <= state_d;
			if (emit_ok) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			if (state_q == nth_pkg::BK_PICK && update) begin
				have_hit_q  <= 1'b1;
				best_dist_q <= tq_dist;
				best_face_q <= face_q;
			end
			if (op_done && op_q >= nth_pkg::OP_PT_X) best_pt_q[pt_axis] <= sat_pt;
			if (emit_ok) begin
				hit_found    <= have_hit_q;
				nearest_face <= best_face_q;
				point_x      <= best_pt_q[0];
				point_y      <= best_pt_q[1];
				point_z      <= best_pt_q[2];
				have_hit_q   <= 1'b0;
				best_dist_q  <= '1;
				best_face_q  <= '0;
				best_pt_q    <= '{default: '0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			face_q <= q_item.face;
			last_q <= q_item.last;
			for (int i = 0; i < 3; i++) begin
				e0_q[i] <= EDGE_W'($signed(q_item.v1[i])) - EDGE_W'($signed(q_item.v0[i]));
				e1_q[i] <= EDGE_W'($signed(q_item.v2[i])) - EDGE_W'($signed(q_item.v0[i]));
				s_q[i]  <= EDGE_W'($signed(ray.org[i])) - EDGE_W'($signed(q_item.v0[i]));
			end
		end
		if (state_q == nth_pkg::BK_LOAD || (state_q == nth_pkg::BK_PICK && update)
				|| (op_done && op_q != nth_pkg::OP_TN_END && op_q != nth_pkg::OP_PT_END)) begin
			op_q   <= ld_op;
			step_q <= '0;
			sreg_q <= ld_sm;
			w_q    <= ld_wd;
			sub_q  <= ld_sub;
			acc_q  <= ld_clr ? ld_acc : acc_sum;
		end else if (state_q == nth_pkg::BK_MAC) begin
			step_q <= step_q + nth_pkg::STEP_W'(1);
			sreg_q <= sreg_q >>> 1;
			w_q    <= w_q <<< 1;
			acc_q  <= acc_sum;
		end
		if (op_done) begin
			unique case (op_q)
				5'd1:  h_q[0]  <= acc_sum[CROSS_W-1:0];
				5'd3:  h_q[1]  <= acc_sum[CROSS_W-1:0];
				5'd5:  h_q[2]  <= acc_sum[CROSS_W-1:0];
				5'd7:  qv_q[0] <= acc_sum[CROSS_W-1:0];
				5'd9:  qv_q[1] <= acc_sum[CROSS_W-1:0];
				5'd11: qv_q[2] <= acc_sum[CROSS_W-1:0];
				5'd14: det_q   <= acc_sum[DOT_W-1:0];
				5'd17: un_q    <= acc_sum[DOT_W-1:0];
				5'd20: vn_q    <= acc_sum[DOT_W-1:0];
				5'd23: tn_q    <= acc_sum[DOT_W-1:0];
				default: ;
			endcase
		end
		if (state_q == nth_pkg::BK_NORM && det_q[DOT_W-1]) begin
			det_q <= -det_q;
			un_q  <= -un_q;
			vn_q  <= -vn_q;
			tn_q  <= -tn_q;
		end
		if (state_q == nth_pkg::BK_TEST) begin
			num_q     <= {tn_q[DOT_W-3:0], {FRAC_W{1'b0}}};
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (state_q == nth_pkg::BK_DIV) begin
			div_cnt_q <= div_cnt_q + nth_pkg::DIV_CNT_W'(1);
			if (!diff[DOT_W]) begin
				rem_q <= diff;
				num_q <= {num_q[TQ_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				num_q <= {num_q[TQ_W-2:0], 1'b0};
			end
		end
	end

	a_div_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nth_pkg::BK_DIV) |-> (!det_q[DOT_W-1] && det_q != '0))
		else $error("divide started with non-positive determinant");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_ok |=> (!have_hit_q && out_valid_q))
		else $error("search state not cleared on result");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == nth_pkg::BK_IDLE))
		else $error("queue popped while busy");

endmodule

// ===== rtl/nearest_triangle_hit.sv =====
// A missed triangle runs the cross- and dot-product MAC operations, a normalize
// and a test; a skipped one is only popped. A hit adds a divide and a compare, a
// new nearest hit the hit-point MACs; the mesh's last triangle posts the result.
// Throughput: one triangle at a time, set by the 34-step shift-add MAC unit
// and the one-bit-per-cycle divider; a two-entry queue feeds them.
// Reset: ray origin 0, direction (0,0,1.0), no skipped face, no hit, queues empty.
module nearest_triangle_hit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [nth_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nth_pkg::COORD_W-1:0]        cfg_data,
	input  logic                               push,
	output logic                               full,
	input  logic signed [nth_pkg::COORD_W-1:0] vertex0_x,
	input  logic signed [nth_pkg::COORD_W-1:0] vertex0_y,
	input  logic signed [nth_pkg::COORD_W-1:0] vertex0_z,
	input  logic signed [nth_pkg::COORD_W-1:0] vertex1_x,
	input  logic signed [nth_pkg::COORD_W-1:0] vertex1_y,
	input  logic signed [nth_pkg::COORD_W-1:0] vertex1_z,
	input  logic signed [nth_pkg::COORD_W-1:0] vertex2_x,
	input  logic signed [nth_pkg::COORD_W-1:0] vertex2_y,
	input  logic signed [nth_pkg::COORD_W-1:0] vertex2_z,
	input  logic [nth_pkg::FACE_W-1:0]         face_index,
	input  logic                               last_face,
	output logic                               empty,
	input  logic                               pop,
	output logic                               hit_found,
	output logic [nth_pkg::FACE_W-1:0]         nearest_face,
	output logic signed [nth_pkg::COORD_W-1:0] point_x,
	output logic signed [nth_pkg::COORD_W-1:0] point_y,
	output logic signed [nth_pkg::COORD_W-1:0] point_z
);

	nth_pkg::item_t in_item;
	nth_pkg::item_t q_item;
	nth_pkg::ray_t  ray;
	logic           q_pop;
	logic           q_empty;

	always_comb begin
		in_item.v0   = {vertex0_z, vertex0_y, vertex0_x};
		in_item.v1   = {vertex1_z, vertex1_y, vertex1_x};
		in_item.v2   = {vertex2_z, vertex2_y, vertex2_x};
		in_item.face = face_index;
		in_item.last = last_face;
		in_item.skip = 1'b0;
	end

	nth_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.q_pop     (q_pop),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.ray       (ray)
	);

	nth_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ray          (ray),
		.q_empty      (q_empty),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.hit_found    (hit_found),
		.nearest_face (nearest_face),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z)
	);

endmodule
